FILE: design/generational_handle_table_top_defines.svh
// ----------------------------------------------------------------------------
// generational handle table assertion macros
// shared property forms used by the top design file
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("handle table check failed");

// next-cycle implication, checked out of reset
`define GHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("handle table check failed");

`endif

FILE: design/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// sizes, codes, types and helpers of the generational handle table
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int TABLE_SLOTS = 4096;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int HINT_W      = SLOT_W + 1;
  localparam int ROW_W       = 64;
  localparam int BIT_W       = $clog2(ROW_W);
  localparam int ROWS        = TABLE_SLOTS / ROW_W;
  localparam int ROW_IDX_W   = $clog2(ROWS);
  localparam int VISIT_W     = ROW_IDX_W + 1;
  localparam int PAY_W       = 64;
  localparam int REF_W       = 32;
  localparam int GEN_W       = 32;
  localparam int HSLOT_W     = 32;
  localparam int ENTRY_W     = PAY_W + REF_W + GEN_W;

  localparam logic [REF_W-1:0] REFS_MAX = '1;

  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_RESOLVE = 2'd1,
    KIND_RETAIN  = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_H_RD,
    S_H_CHK,
    S_C_RD,
    S_C_CHK,
    S_C_GWR
  } state_t;

  typedef struct packed {
    logic [PAY_W-1:0] payload;
    logic [REF_W-1:0] refs;
    logic [GEN_W-1:0] gen;
  } entry_t;

  // index of the lowest set bit of a bitmap row
  function automatic logic [BIT_W-1:0] low_one(input logic [ROW_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

FILE: design/ght_ram.sv
// ----------------------------------------------------------------------------
// ght_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: design/generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// generational handle table top
// resolve, retain, release: read the entry and its bitmap row, then check and register the result
// create: scan 64-slot bitmap rows from the hint, wrapping once, then write the new generation
// one transaction at a time; a waiting result does not block the next accept
// after reset a clearing pass over all 4096 slots sets every generation to one, in_ready low
// ----------------------------------------------------------------------------
module generational_handle_table_top
  import ght_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [PAY_W-1:0]   in_payload_in,
  input  logic [HSLOT_W-1:0] in_slot_in,
  input  logic [GEN_W-1:0]   in_generation_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [SLOT_W-1:0]  out_slot_out,
  output logic [GEN_W-1:0]   out_generation_out,
  output logic [PAY_W-1:0]   out_payload_out
);

  `include "generational_handle_table_top_defines.svh"

  state_t               state_r, state_nxt;
  logic [SLOT_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  kind_t                kind_r, kind_nxt;
  logic [PAY_W-1:0]     payload_r, payload_nxt;
  logic [HSLOT_W-1:0]   slot_r, slot_nxt;
  logic [GEN_W-1:0]     gen_in_r, gen_in_nxt;
  logic [HINT_W-1:0]    hint_r, hint_nxt;
  logic [ROW_IDX_W-1:0] row_r, row_nxt;
  logic [VISIT_W-1:0]   visit_r, visit_nxt;
  logic [SLOT_W-1:0]    cslot_r, cslot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [GEN_W-1:0]     out_gen_r, out_gen_nxt;
  logic [PAY_W-1:0]     out_pay_r, out_pay_nxt;

  logic                 ent_we, ent_re;
  logic [SLOT_W-1:0]    ent_waddr, ent_raddr;
  logic [ENTRY_W-1:0]   ent_wdata, ent_rdata;
  entry_t               ent_q, ent_w;
  logic                 bm_we, bm_re;
  logic [ROW_IDX_W-1:0] bm_waddr, bm_raddr;
  logic [ROW_W-1:0]     bm_wdata, bm_rdata;

  logic                 out_free;
  logic                 h_ok;
  logic [ROW_W-1:0]     scan_mask, avail;
  logic                 found;
  logic [SLOT_W-1:0]    found_slot;
  logic [GEN_W-1:0]     new_gen;

  ght_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // active flags, one bit per slot, 64 slots to a row
  ght_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_active_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  assign ent_q     = entry_t'(ent_rdata);
  assign ent_wdata = ENTRY_W'(ent_w);
  assign out_free  = !out_valid_r || out_ready;

  assign h_ok = (slot_r[HSLOT_W-1:SLOT_W] == '0) && (slot_r[SLOT_W-1:0] != '0)
                && bm_rdata[slot_r[BIT_W-1:0]] && (ent_q.gen == gen_in_r);

  // first visit of the start row scans from the hint up, the wrap visit below it
  always_comb begin
    scan_mask = '1;
    if (visit_r == '0) begin
      scan_mask = {ROW_W{1'b1}} << hint_r[BIT_W-1:0];
    end else if (visit_r == VISIT_W'(ROWS)) begin
      scan_mask = ~({ROW_W{1'b1}} << hint_r[BIT_W-1:0]);
    end
    if (row_r == '0) scan_mask[0] = 1'b0;
  end

  assign avail      = ~bm_rdata & scan_mask;
  assign found      = |avail;
  assign found_slot = {row_r, low_one(avail)};
  assign new_gen    = (ent_q.gen + 1'b1 == '0) ? GEN_W'(1) : ent_q.gen + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    kind_nxt       = kind_r;
    payload_nxt    = payload_r;
    slot_nxt       = slot_r;
    gen_in_nxt     = gen_in_r;
    hint_nxt       = hint_r;
    row_nxt        = row_r;
    visit_nxt      = visit_r;
    cslot_nxt      = cslot_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_gen_nxt    = out_gen_r;
    out_pay_nxt    = out_pay_r;
    in_ready       = 1'b0;
    ent_we         = 1'b0;
    ent_waddr      = slot_r[SLOT_W-1:0];
    ent_w          = ent_q;
    ent_re         = 1'b0;
    ent_raddr      = slot_r[SLOT_W-1:0];
    bm_we          = 1'b0;
    bm_waddr       = slot_r[SLOT_W-1:BIT_W];
    bm_wdata       = bm_rdata;
    bm_re          = 1'b0;
    bm_raddr       = row_r;

    unique case (state_r)
      S_CLR: begin
        ent_we      = 1'b1;
        ent_waddr   = clr_cnt_r;
        ent_w       = '{payload: '0, refs: '0, gen: GEN_W'(1)};
        bm_we       = 1'b1;
        bm_waddr    = clr_cnt_r[ROW_IDX_W-1:0];
        bm_wdata    = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SLOT_W'(TABLE_SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt    = kind_t'(in_kind);
          payload_nxt = in_payload_in;
          slot_nxt    = in_slot_in;
          gen_in_nxt  = in_generation_in;
          row_nxt     = hint_r[SLOT_W-1:BIT_W];
          visit_nxt   = '0;
          state_nxt   = (kind_t'(in_kind) == KIND_CREATE) ? S_C_RD : S_H_RD;
        end
      end
      S_H_RD: begin
        ent_re    = 1'b1;
        bm_re     = 1'b1;
        bm_raddr  = slot_r[SLOT_W-1:BIT_W];
        state_nxt = S_H_CHK;
      end
      S_H_CHK: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = h_ok ? ST_OK : ST_BAD;
          out_slot_nxt   = '0;
          out_gen_nxt    = '0;
          out_pay_nxt    = (h_ok && kind_r == KIND_RESOLVE) ? ent_q.payload : '0;
          if (h_ok && kind_r == KIND_RETAIN && ent_q.refs != REFS_MAX) begin
            ent_we     = 1'b1;
            ent_w.refs = ent_q.refs + 1'b1;
          end
          if (h_ok && kind_r == KIND_RELEASE && ent_q.refs != '0) begin
            ent_we     = 1'b1;
            ent_w.refs = ent_q.refs - 1'b1;
            // last reference gone: free the slot and point the search at it
            if (ent_q.refs == REF_W'(1)) begin
              ent_w.payload                 = '0;
              bm_we                         = 1'b1;
              bm_wdata[slot_r[BIT_W-1:0]]   = 1'b0;
              hint_nxt                      = {1'b0, slot_r[SLOT_W-1:0]};
            end
          end
          state_nxt = S_IDLE;
        end
      end
      S_C_RD: begin
        bm_re     = 1'b1;
        state_nxt = S_C_CHK;
      end
      S_C_CHK: begin
        if (found) begin
          cslot_nxt              = found_slot;
          bm_we                  = 1'b1;
          bm_waddr               = row_r;
          bm_wdata[low_one(avail)] = 1'b1;
          ent_re                 = 1'b1;
          ent_raddr              = found_slot;
          state_nxt              = S_C_GWR;
        end else if (visit_r == VISIT_W'(ROWS)) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FULL;
            out_slot_nxt   = '0;
            out_gen_nxt    = '0;
            out_pay_nxt    = '0;
            state_nxt      = S_IDLE;
          end
        end else begin
          row_nxt   = row_r + 1'b1;
          visit_nxt = visit_r + 1'b1;
          state_nxt = S_C_RD;
        end
      end
      S_C_GWR: begin
        if (out_free) begin
          ent_we         = 1'b1;
          ent_waddr      = cslot_r;
          ent_w          = '{payload: payload_r, refs: REF_W'(1), gen: new_gen};
          hint_nxt       = {1'b0, cslot_r} + 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_slot_nxt   = cslot_r;
          out_gen_nxt    = new_gen;
          out_pay_nxt    = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      hint_r      <= HINT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    payload_r    <= payload_nxt;
    slot_r       <= slot_nxt;
    gen_in_r     <= gen_in_nxt;
    row_r        <= row_nxt;
    visit_r      <= visit_nxt;
    cslot_r      <= cslot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_gen_r    <= out_gen_nxt;
    out_pay_r    <= out_pay_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot_out       = out_slot_r;
  assign out_generation_out = out_gen_r;
  assign out_payload_out    = out_pay_r;

  `GHT_ASSERT_NOW(a_no_accept_in_clear, state_r == S_CLR, !in_ready)
  `GHT_ASSERT_NOW(a_fail_fields_zero, out_valid_r && out_status_r != ST_OK,
                  out_slot_r == '0 && out_gen_r == '0 && out_pay_r == '0)
  `GHT_ASSERT_NOW(a_slot0_never_found, state_r == S_C_CHK && found, found_slot != '0)
  `GHT_ASSERT_NOW(a_hint_nonzero, 1'b1, hint_r != '0)
  `GHT_ASSERT_NEXT(a_create_gen_nonzero, state_r == S_C_GWR && out_free,
                   out_valid_r && out_gen_r != '0 && out_slot_r != '0)

endmodule
